// ----- design/asgr_pkg.sv -----
// package for the sgr colour parser
// holds parse phase type, character codes, palette table and the result beat struct
// no dependencies
package asgr_pkg;

  localparam int MAX_PARAMS_DEF = 8;

  localparam logic [15:0] CH_ESC   = 16'h001b;
  localparam logic [15:0] CH_BRACK = 16'h005b;
  localparam logic [15:0] CH_SEMI  = 16'h003b;
  localparam logic [15:0] CH_M     = 16'h006d;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;

  localparam logic [15:0] SGR_RESET  = 16'd0;
  localparam logic [15:0] SGR_EXT_FG = 16'd38;
  localparam logic [15:0] SGR_RGB    = 16'd2;
  localparam logic [15:0] SGR_FG_LO  = 16'd30;
  localparam logic [15:0] SGR_FG_HI  = 16'd37;

  localparam logic [31:0] COLOUR_WHITE  = 32'hffffffff;
  localparam logic [31:0] COLOUR_OPAQUE = 32'hff000000;

  typedef enum logic [1:0] {
    PH_PRINT     = 2'd0,
    PH_ESC       = 2'd1,
    PH_SEQ_EMPTY = 2'd2,
    PH_SEQ_ANY   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] printed_char;
    logic [31:0] char_colour;
    logic        end_of_write;
  } result_t;

  function automatic logic [31:0] palette(input logic [2:0] idx);
    logic [31:0] c;
    unique case (idx)
      3'd0: c = 32'hff000000;
      3'd1: c = 32'hffcc0000;
      3'd2: c = 32'hff009a00;
      3'd3: c = 32'hffc4a000;
      3'd4: c = 32'hff0065a4;
      3'd5: c = 32'hff75507b;
      3'd6: c = 32'hff00989a;
      3'd7: c = 32'hffd0d0d0;
      default: c = COLOUR_WHITE;
    endcase
    return c;
  endfunction

endpackage

// ----- design/asgr_core.sv -----
// input register, parse state and one-step parse logic of the sgr colour parser
// depends on asgr_pkg
module asgr_core #(
  parameter int MAX_PARAMS = asgr_pkg::MAX_PARAMS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      char_code,
  input  logic             end_of_write,
  output logic             res_valid,
  input  logic             res_ready,
  output asgr_pkg::result_t res
);
  import asgr_pkg::*;

  localparam int CNTW = $clog2(MAX_PARAMS + 1);
  localparam int IDXW = $clog2(MAX_PARAMS);
  localparam int NUSE = 5;

  logic              hold_valid;
  logic [15:0]       hold_char;
  logic              hold_eow;

  phase_t            phase;
  phase_t            phase_next;
  logic [15:0]       number;
  logic [15:0]       number_next;
  logic [CNTW-1:0]   param_count;
  logic [CNTW-1:0]   param_count_next;
  logic [31:0]       colour;
  logic [31:0]       colour_next;
  logic [15:0]       param_store [MAX_PARAMS];

  logic              step;
  logic              emit;
  logic              is_digit;
  logic              push;
  logic              room;
  logic [19:0]       mul_sum;
  logic [15:0]       digit_val;
  logic [15:0]       p_eff [NUSE];
  logic [CNTW-1:0]   cnt_eff;
  logic [31:0]       applied;
  logic [15:0]       pal_off;

  assign is_digit  = (hold_char >= CH_ZERO) && (hold_char <= CH_NINE);
  assign mul_sum   = {1'b0, number, 3'b000} + {3'b000, number, 1'b0} + {16'd0, hold_char[3:0]};
  assign digit_val = (mul_sum[19:16] != 4'd0) ? 16'hffff : mul_sum[15:0];
  assign room      = param_count < CNTW'(MAX_PARAMS);

  // parameter push on ';' or on 'm' after a digit or ';'
  always_comb begin
    push = 1'b0;
    if (phase == PH_SEQ_EMPTY || phase == PH_SEQ_ANY) begin
      if (!is_digit && hold_char == CH_SEMI) begin
        push = 1'b1;
      end else if (!is_digit && hold_char == CH_M && phase == PH_SEQ_ANY) begin
        push = 1'b1;
      end
    end
  end

  // parameter list as seen after this beat's push
  always_comb begin
    for (int i = 0; i < NUSE; i++) begin
      p_eff[i] = (push && param_count == CNTW'(i)) ? number : param_store[i];
    end
    cnt_eff = (push && room) ? param_count + 1'b1 : param_count;
  end

  assign pal_off = p_eff[1] - SGR_FG_LO;

  always_comb begin
    applied = colour;
    if (cnt_eff == '0) begin
      applied = COLOUR_WHITE;
    end else if (p_eff[0] == SGR_RESET) begin
      if (cnt_eff >= CNTW'(2) && p_eff[1] >= SGR_FG_LO && p_eff[1] <= SGR_FG_HI) begin
        applied = palette(pal_off[2:0]);
      end
    end else if (p_eff[0] == SGR_EXT_FG) begin
      if (cnt_eff >= CNTW'(NUSE) && p_eff[1] == SGR_RGB) begin
        applied = COLOUR_OPAQUE | {8'd0, p_eff[2][7:0], p_eff[3][7:0], p_eff[4][7:0]};
      end
    end
  end

  // next state
  always_comb begin
    phase_next       = phase;
    number_next      = number;
    param_count_next = param_count;
    colour_next      = colour;
    unique case (phase)
      PH_ESC: begin
        if (hold_char == CH_BRACK) begin
          phase_next       = PH_SEQ_EMPTY;
          param_count_next = '0;
          number_next      = '0;
        end else begin
          phase_next = PH_PRINT;
        end
      end
      PH_SEQ_EMPTY, PH_SEQ_ANY: begin
        if (is_digit) begin
          number_next = digit_val;
          phase_next  = PH_SEQ_ANY;
        end else if (hold_char == CH_SEMI) begin
          number_next      = '0;
          param_count_next = cnt_eff;
          phase_next       = PH_SEQ_ANY;
        end else if (hold_char == CH_M) begin
          number_next      = '0;
          param_count_next = cnt_eff;
          colour_next      = applied;
          phase_next       = PH_PRINT;
        end
      end
      default: begin
        phase_next = (hold_char == CH_ESC) ? PH_ESC : PH_PRINT;
      end
    endcase
  end

  // outputs
  always_comb begin
    emit             = hold_valid && (phase == PH_PRINT) && (hold_char != CH_ESC);
    res.printed_char = hold_char;
    res.char_colour  = colour;
    res.end_of_write = hold_eow;
  end

  assign res_valid = emit;
  assign step      = hold_valid && (!emit || res_ready);
  assign in_ready  = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_char <= char_code;
      hold_eow  <= end_of_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PRINT;
      number      <= '0;
      param_count <= '0;
      colour      <= COLOUR_WHITE;
    end else if (step) begin
      phase       <= phase_next;
      number      <= number_next;
      param_count <= param_count_next;
      colour      <= colour_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && push && room) begin
      param_store[param_count[IDXW-1:0]] <= number;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    param_count <= CNTW'(MAX_PARAMS))
    else $error("parameter count beyond store");
  a_esc_enter: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_PRINT && hold_char == CH_ESC |=> phase == PH_ESC)
    else $error("escape not taken");
  a_seq_open: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_ESC && hold_char == CH_BRACK |=>
      param_count == '0 && number == '0 && phase == PH_SEQ_EMPTY)
    else $error("sequence open did not clear list");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !step |=> hold_valid && $stable(hold_char))
    else $error("held beat lost while stalled");
`endif

endmodule

// ----- design/asgr_out_reg.sv -----
// result register of the sgr colour parser
// depends on asgr_pkg
module asgr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  asgr_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output asgr_pkg::result_t out_data
);
  import asgr_pkg::*;

  logic load;

  assign res_ready = !out_valid || out_ready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (load) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && out_data == $past(res))
    else $error("loaded result not shown");
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");
  a_no_load_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !load)
    else $error("result overwritten while stalled");
`endif

endmodule

// ----- design/ansi_sgr_colour_parser.sv -----
// top level of the sgr colour parser
// depends on asgr_pkg, asgr_core, asgr_out_reg
//
// input channel: in_valid/in_ready carry one character beat (char_code,
// end_of_write). output channel: out_valid/out_ready carry one printed
// character beat (printed_char, char_colour, end_of_write_out).
// plain characters in the printing phase give one output beat with the
// colour in force; ESC, the character after it and everything inside an
// escape sequence give none, and an end_of_write mark on them is dropped.
// a character passes through the input register, then the result register,
// before it shows on the output.
// throughput: one character per cycle while out_ready is high; the parse
// state is updated once per character, so back-to-back beats need no gaps.
// reset (rst, synchronous) empties both registers, returns to the printing
// phase and sets the colour to white (0xffffffff).
// when out_ready is low the result register holds its beat; the input
// register still takes one more character and then holds in_ready low,
// except that characters making no output keep flowing through.
module ansi_sgr_colour_parser #(
  parameter int MAX_PARAMS = asgr_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] char_code,
  input  logic        end_of_write,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] printed_char,
  output logic [31:0] char_colour,
  output logic        end_of_write_out
);
  import asgr_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_data;

  asgr_core #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .end_of_write (end_of_write),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  asgr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign printed_char     = out_data.printed_char;
  assign char_colour      = out_data.char_colour;
  assign end_of_write_out = out_data.end_of_write;

endmodule

// ----- verif/ansi_sgr_colour_parser_tb.sv -----
// testbench for ansi_sgr_colour_parser: character beats in, printed character beats out
// checks every output beat against an in-bench escape sequence parser, with random stalls
// depends on asgr_pkg and ansi_sgr_colour_parser
module ansi_sgr_colour_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asgr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 500;
  localparam logic [8*32-1:0] FG_PALETTE = {
    32'hffd0d0d0, 32'hff00989a, 32'hff75507b, 32'hff0065a4,
    32'hffc4a000, 32'hff009a00, 32'hffcc0000, 32'hff000000
  };

  typedef struct {
    logic [15:0] code;
    logic        eow;
  } char_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] char_code = '0;
  logic        end_of_write = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] printed_char;
  logic [31:0] char_colour;
  logic        end_of_write_out;

  char_beat_t pending_chars[$];
  result_t    expected_prints[$];

  // parser state as the block should hold it
  phase_t      parse_ph = PH_PRINT;
  logic [15:0] cur_num = '0;
  logic [15:0] param_vals [MAX_PARAMS_DEF];
  int          param_cnt = 0;
  logic [31:0] cur_colour = COLOUR_WHITE;

  int mismatches = 0;
  int sent_count = 0;
  int accepted_count = 0;
  int printed_count = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  ansi_sgr_colour_parser dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .char_code        (char_code),
    .end_of_write     (end_of_write),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .printed_char     (printed_char),
    .char_colour      (char_colour),
    .end_of_write_out (end_of_write_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void store_param();
    if (param_cnt < MAX_PARAMS_DEF) begin
      param_vals[param_cnt] = cur_num;
      param_cnt++;
    end
    cur_num = '0;
  endfunction

  function automatic void apply_sgr();
    int idx;
    if (param_cnt == 0) begin
      cur_colour = COLOUR_WHITE;
    end else if (param_vals[0] == SGR_RESET) begin
      if (param_cnt >= 2 && param_vals[1] >= SGR_FG_LO && param_vals[1] <= SGR_FG_HI) begin
        idx = int'(param_vals[1]) - int'(SGR_FG_LO);
        cur_colour = FG_PALETTE[idx*32 +: 32];
      end
    end else if (param_vals[0] == SGR_EXT_FG) begin
      if (param_cnt >= 5 && param_vals[1] == SGR_RGB)
        cur_colour = {COLOUR_OPAQUE[31:24], param_vals[2][7:0], param_vals[3][7:0],
                      param_vals[4][7:0]};
    end
  endfunction

  function automatic void parse_char(input logic [15:0] code, input logic eow);
    int unsigned acc;
    result_t     r;
    case (parse_ph)
      PH_ESC: begin
        if (code == CH_BRACK) begin
          parse_ph = PH_SEQ_EMPTY;
          param_cnt = 0;
          cur_num = '0;
        end else begin
          parse_ph = PH_PRINT;
        end
      end
      PH_SEQ_EMPTY, PH_SEQ_ANY: begin
        if (code >= CH_ZERO && code <= CH_NINE) begin
          acc = int'(cur_num) * 10 + int'(code) - int'(CH_ZERO);
          cur_num = (acc > 65535) ? 16'hffff : acc[15:0];
          parse_ph = PH_SEQ_ANY;
        end else if (code == CH_SEMI) begin
          store_param();
          parse_ph = PH_SEQ_ANY;
        end else if (code == CH_M) begin
          if (parse_ph == PH_SEQ_ANY)
            store_param();
          apply_sgr();
          cur_num = '0;
          parse_ph = PH_PRINT;
        end
      end
      default: begin
        if (code == CH_ESC) begin
          parse_ph = PH_ESC;
        end else begin
          r.printed_char = code;
          r.char_colour = cur_colour;
          r.end_of_write = eow;
          expected_prints.push_back(r);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  task automatic push_beat(input logic [15:0] code, input logic eow);
    char_beat_t b;
    b.code = code;
    b.eow = eow;
    pending_chars.push_back(b);
  endtask

  task automatic push_char(input logic [15:0] code);
    push_beat(code, $urandom_range(7) == 0);
  endtask

  task automatic push_num(input longint unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++)
      push_char({8'h00, digits[i]});
  endtask

  task automatic open_seq();
    push_char(CH_ESC);
    push_char(CH_BRACK);
  endtask

  function automatic logic [15:0] plain_code();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60)
      return 16'($urandom_range(32, 126));
    else if (pick < 90)
      return 16'($urandom_range(0, 65535));
    else
      case ($urandom_range(3))
        0: return 16'h0000;
        1: return 16'hffff;
        2: return 16'h8000;
        default: return 16'h7fff;
      endcase
  endfunction

  function automatic longint unsigned random_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 40);
      6, 7: return $urandom_range(0, 999);
      8: return $urandom_range(0, 65535);
      default: return 64'd65536 + $urandom;
    endcase
  endfunction

  task automatic gen_sequence();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 35) begin
      n = $urandom_range(1, 4);
      repeat (n) push_char(plain_code());
    end else if (kind < 50) begin
      // palette select, sometimes out of range
      open_seq();
      if ($urandom_range(4) == 0)
        push_char(CH_ZERO);
      push_num(($urandom_range(9) == 0) ? random_value() : 0);
      push_char(CH_SEMI);
      push_num($urandom_range(28, 39));
      push_char(CH_M);
    end else if (kind < 65) begin
      // direct colour, sometimes short or malformed
      open_seq();
      push_num(38);
      push_char(CH_SEMI);
      push_num(($urandom_range(9) == 0) ? random_value() : 2);
      n = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : 3 + ($urandom_range(3) == 0);
      repeat (n) begin
        push_char(CH_SEMI);
        push_num(random_value());
      end
      push_char(CH_M);
    end else if (kind < 72) begin
      open_seq();
      push_char(CH_M);
    end else if (kind < 85) begin
      // arbitrary list with empty params, noise and overflow of the store
      open_seq();
      n = $urandom_range(0, 12);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(4) != 0)
          push_num(random_value());
        if ($urandom_range(5) == 0)
          push_char(plain_code());
        if (k < n - 1)
          push_char(CH_SEMI);
      end
      push_char(CH_M);
    end else if (kind < 92) begin
      push_char(CH_ESC);
      push_char(plain_code());
    end else begin
      // broken sequence left open
      open_seq();
      push_num(random_value());
      n = $urandom_range(1, 3);
      repeat (n) push_char(plain_code());
    end
  endtask

  // driver
  always @(posedge clk) begin : driver
    char_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(char_code, end_of_write);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_chars.size() != 0 &&
            ((sent_count >= 300 && sent_count < 420) || $urandom_range(99) >= 30)) begin
          nxt = pending_chars.pop_front();
          sent_count++;
          in_valid <= 1'b1;
          char_code <= nxt.code;
          end_of_write <= nxt.eow;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        printed_count++;
        if (expected_prints.size() == 0) begin
          report_mismatch("unexpected beat, printed_char", printed_char, '0);
        end else begin
          want = expected_prints.pop_front();
          if (printed_char !== want.printed_char)
            report_mismatch("printed_char", printed_char, want.printed_char);
          if (char_colour !== want.char_colour)
            report_mismatch("char_colour", char_colour, want.char_colour);
          if (end_of_write_out !== want.end_of_write)
            report_mismatch("end_of_write_out", end_of_write_out, want.end_of_write);
        end
        // long back-pressure so the block fills up
        if (printed_count == 10)
          hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (printed_count >= 20 && printed_count < 40) ||
                     $urandom_range(99) >= 30;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("** ansi_sgr_colour_parser: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int total_items;
    // directed: extremes, dropped char after esc, palette, empty list
    push_beat(16'h0041, 1'b1);
    push_beat(16'hffff, 1'b0);
    push_beat(16'h0000, 1'b1);
    push_beat(CH_ESC, 1'b0);
    push_beat(16'h0078, 1'b1);
    push_beat(16'h0042, 1'b0);
    push_beat(CH_ESC, 1'b0);
    push_beat(CH_BRACK, 1'b0);
    push_beat(CH_ZERO, 1'b0);
    push_beat(CH_SEMI, 1'b0);
    push_beat(16'h0033, 1'b0);
    push_beat(16'h0031, 1'b1);
    push_beat(CH_M, 1'b0);
    push_beat(16'h0043, 1'b1);
    push_beat(CH_ESC, 1'b0);
    push_beat(CH_BRACK, 1'b0);
    push_beat(CH_M, 1'b0);
    push_beat(16'h0044, 1'b0);
    push_beat(CH_ESC, 1'b0);
    push_beat(CH_BRACK, 1'b0);
    push_beat(CH_SEMI, 1'b0);
    push_beat(CH_M, 1'b0);
    push_beat(16'h0045, 1'b1);
    while (pending_chars.size() < RANDOM_ITEMS)
      gen_sequence();
    // close any open sequence so the tail prints
    push_beat(CH_M, 1'b0);
    push_beat(16'h005a, 1'b1);
    total_items = pending_chars.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items)
      @(posedge clk);
    while (expected_prints.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_prints.size() == 0)
      $display("** ansi_sgr_colour_parser: PASSED **");
    else
      $display("** ansi_sgr_colour_parser: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/asgr_pkg.sv
design/asgr_core.sv
design/asgr_out_reg.sv
design/ansi_sgr_colour_parser.sv
verif/ansi_sgr_colour_parser_tb.sv
